@@ rtl/hge_pkg.sv @@
package hge_pkg;

  localparam int POS_BITS   = 16;
  localparam int FIELD_BITS = 16;

  localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0] COUNT_MAX = {FIELD_BITS{1'b1}};

  localparam logic [31:0] WORD_GET   = 32'h47455420;
  localparam logic [31:0] WORD_HOST1 = 32'h486F7374;
  localparam logic [31:0] WORD_HOST2 = 32'h686F7374;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_SKIP   = 3'd1,
    PH_URL    = 3'd2,
    PH_SEARCH = 3'd3,
    PH_COLON  = 3'd4,
    PH_SPACE  = 3'd5,
    PH_HOST   = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    OC_FOUND    = 3'd0,
    OC_NOT_GET  = 3'd1,
    OC_NO_URL   = 3'd2,
    OC_NO_HOST  = 3'd3,
    OC_BAD_SEP  = 3'd4,
    OC_NO_END   = 3'd5,
    OC_TOO_LONG = 3'd6
  } outcome_t;

  typedef struct packed {
    outcome_t              outcome;
    logic [FIELD_BITS-1:0] url_offset;
    logic [FIELD_BITS-1:0] url_len;
    logic [FIELD_BITS-1:0] host_offset;
    logic [FIELD_BITS-1:0] host_len;
  } result_t;

endpackage

@@ rtl/hge_out_buf.sv @@
module hge_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hge_pkg::result_t push_data,
  output logic             full,
  output logic             head_valid,
  input  logic             head_stall,
  output hge_pkg::result_t head_data
);

  logic             skid_valid;
  hge_pkg::result_t skid_data;
  logic             pop;

  assign pop  = head_valid && !head_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
        head_data  <= push_data;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
        head_data  <= push_data;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

endmodule

@@ rtl/http_get_host_url_extractor_top.sv @@
// channel  | signals                                  | direction
// ---------+------------------------------------------+----------
// in       | in_valid, in_stall, data_byte, last_byte | into block
// out      | out_valid, out_stall, outcome, url_*, host_* | out of block
//
// one byte a cycle unless in_stall is high; results are registered in the buffer
// parse state updates at every accepted byte, the result goes to a two-entry buffer
// in_stall rises only when both buffer entries hold results that wait on out_stall
// rst is synchronous and active high, and returns the parser to the method check
module http_get_host_url_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  outcome,
  output logic [15:0] url_offset,
  output logic [15:0] url_len,
  output logic [15:0] host_offset,
  output logic [15:0] host_len
);

  hge_pkg::phase_t                  phase, phase_next;
  logic [hge_pkg::POS_BITS-1:0]     position, position_next;
  logic [39:0]                      recent_bytes, recent_bytes_next;
  logic [hge_pkg::POS_BITS-1:0]     url_begin, url_begin_next;
  logic [hge_pkg::POS_BITS-1:0]     url_size, url_size_next;
  logic [hge_pkg::POS_BITS-1:0]     host_begin, host_begin_next;
  logic [hge_pkg::FIELD_BITS-1:0]   host_count, host_count_next;
  logic                             colon_seen, colon_seen_next;
  hge_pkg::outcome_t                status_held, status_held_next;

  logic             in_fire;
  logic             push;
  logic             buf_full;
  logic [7:0]       prev;
  logic [39:0]      shifted;
  hge_pkg::result_t res;
  hge_pkg::result_t head;
  hge_pkg::outcome_t code;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !in_stall;
  assign push     = in_fire && last_byte;
  assign prev     = recent_bytes[7:0];
  assign shifted  = {recent_bytes[31:0], data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hge_pkg::PH_METHOD;
      position     <= '0;
      recent_bytes <= '0;
      url_begin    <= '0;
      url_size     <= '0;
      host_begin   <= '0;
      host_count   <= '0;
      colon_seen   <= 1'b0;
      status_held  <= hge_pkg::OC_FOUND;
    end else begin
      phase        <= phase_next;
      position     <= position_next;
      recent_bytes <= recent_bytes_next;
      url_begin    <= url_begin_next;
      url_size     <= url_size_next;
      host_begin   <= host_begin_next;
      host_count   <= host_count_next;
      colon_seen   <= colon_seen_next;
      status_held  <= status_held_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    position_next     = position;
    recent_bytes_next = recent_bytes;
    url_begin_next    = url_begin;
    url_size_next     = url_size;
    host_begin_next   = host_begin;
    host_count_next   = host_count;
    colon_seen_next   = colon_seen;
    status_held_next  = status_held;
    code              = hge_pkg::OC_FOUND;
    res               = '0;

    if (in_fire) begin
      if (position == hge_pkg::POS_MAX) begin
        phase_next       = hge_pkg::PH_DONE;
        status_held_next = hge_pkg::OC_TOO_LONG;
      end else begin
        recent_bytes_next = shifted;
        position_next     = position + 1'b1;
        unique case (phase)
          hge_pkg::PH_METHOD: begin
            if (position == hge_pkg::POS_BITS'(3)) begin
              if (shifted[31:0] == hge_pkg::WORD_GET) begin
                phase_next = hge_pkg::PH_SKIP;
              end else begin
                phase_next       = hge_pkg::PH_DONE;
                status_held_next = hge_pkg::OC_NOT_GET;
              end
            end
          end
          hge_pkg::PH_SKIP: begin
            if (data_byte == hge_pkg::CH_CR || data_byte == hge_pkg::CH_LF) begin
              phase_next       = hge_pkg::PH_DONE;
              status_held_next = hge_pkg::OC_NO_URL;
            end else if (data_byte != hge_pkg::CH_SP) begin
              url_begin_next = position;
              phase_next     = hge_pkg::PH_URL;
            end
          end
          hge_pkg::PH_URL: begin
            if (data_byte == hge_pkg::CH_SP) begin
              url_size_next     = position - url_begin;
              recent_bytes_next = '0;
              phase_next        = hge_pkg::PH_SEARCH;
            end else if (data_byte == hge_pkg::CH_CR || data_byte == hge_pkg::CH_LF) begin
              phase_next       = hge_pkg::PH_DONE;
              status_held_next = hge_pkg::OC_NO_URL;
            end
          end
          hge_pkg::PH_SEARCH: begin
            if (shifted == {hge_pkg::CH_LF, hge_pkg::WORD_HOST1} ||
                shifted == {hge_pkg::CH_LF, hge_pkg::WORD_HOST2}) begin
              phase_next = hge_pkg::PH_COLON;
            end
          end
          hge_pkg::PH_COLON: begin
            if (data_byte == hge_pkg::CH_COLON) begin
              phase_next = hge_pkg::PH_SPACE;
            end else begin
              phase_next       = hge_pkg::PH_DONE;
              status_held_next = hge_pkg::OC_BAD_SEP;
            end
          end
          hge_pkg::PH_SPACE: begin
            if (data_byte == hge_pkg::CH_SP) begin
              host_begin_next = position + 1'b1;
              host_count_next = '0;
              colon_seen_next = 1'b0;
              phase_next      = hge_pkg::PH_HOST;
            end else begin
              phase_next       = hge_pkg::PH_DONE;
              status_held_next = hge_pkg::OC_BAD_SEP;
            end
          end
          hge_pkg::PH_HOST: begin
            if (data_byte == hge_pkg::CH_LF) begin
              if (prev == hge_pkg::CH_CR && !colon_seen && host_count != '0) begin
                host_count_next = host_count - 1'b1;
              end
              status_held_next = hge_pkg::OC_FOUND;
              phase_next       = hge_pkg::PH_DONE;
            end else if (!colon_seen) begin
              if (data_byte == hge_pkg::CH_COLON) begin
                colon_seen_next = 1'b1;
              end else if (host_count != hge_pkg::COUNT_MAX) begin
                host_count_next = host_count + 1'b1;
              end
            end
          end
          hge_pkg::PH_DONE: begin
          end
        endcase
      end

      unique case (phase_next)
        hge_pkg::PH_METHOD: code = hge_pkg::OC_NOT_GET;
        hge_pkg::PH_SKIP,
        hge_pkg::PH_URL:    code = hge_pkg::OC_NO_URL;
        hge_pkg::PH_SEARCH: code = hge_pkg::OC_NO_HOST;
        hge_pkg::PH_COLON,
        hge_pkg::PH_SPACE:  code = hge_pkg::OC_BAD_SEP;
        hge_pkg::PH_HOST:   code = hge_pkg::OC_NO_END;
        hge_pkg::PH_DONE:   code = status_held_next;
      endcase

      res.outcome = code;
      if (code == hge_pkg::OC_FOUND) begin
        res.url_offset  = hge_pkg::FIELD_BITS'(url_begin_next);
        res.url_len     = hge_pkg::FIELD_BITS'(url_size_next);
        res.host_offset = hge_pkg::FIELD_BITS'(host_begin_next);
        res.host_len    = host_count_next;
      end

      if (last_byte) begin
        phase_next        = hge_pkg::PH_METHOD;
        position_next     = '0;
        recent_bytes_next = '0;
        url_begin_next    = '0;
        url_size_next     = '0;
        host_begin_next   = '0;
        host_count_next   = '0;
        colon_seen_next   = 1'b0;
        status_held_next  = hge_pkg::OC_FOUND;
      end
    end
  end

  hge_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .full       (buf_full),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head_data  (head)
  );

  assign outcome     = head.outcome;
  assign url_offset  = head.url_offset;
  assign url_len     = head.url_len;
  assign host_offset = head.host_offset;
  assign host_len    = head.host_len;

endmodule

@@ rtl/hge_checker.sv @@
module hge_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  outcome,
  input logic [15:0] url_offset,
  input logic [15:0] url_len,
  input logic [15:0] host_offset,
  input logic [15:0] host_len
);

  // a failed beat carries no offsets or lengths
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome != hge_pkg::OC_FOUND) |->
      (url_offset == '0 && url_len == '0 && host_offset == '0 && host_len == '0))
    else $error("failure beat with nonzero fields");

  // a found url sits after the method word, and the host after the url
  a_found_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == hge_pkg::OC_FOUND) |->
      (url_offset >= 16'd4 && host_offset > url_offset))
    else $error("found beat with impossible offsets");

  // input stalls only while a result waits
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("result pending after reset");

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(outcome) && $stable(host_len)))
    else $error("stalled result beat dropped or changed");

endmodule

bind http_get_host_url_extractor_top hge_checker u_hge_checker (.*);
